// ----- rtl/ghal_pkg.sv -----
// Shared types and codes of the generational handle allocator.
// Used by ghal_front, ghal_back, the top level and ghal_checker; no dependencies.
`default_nettype none

package ghal_pkg;

  localparam int FieldW   = 8;
  localparam int InDataW  = 16;
  localparam int OutDataW = 32;

  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_DESTROY = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_NOT_ALIVE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_CREATE  = 2'd0,
    KIND_DESTROY = 2'd1,
    KIND_QUERY   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [FieldW-1:0] slot;
    logic [FieldW-1:0] version;
    logic              usable;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/ghal_front.sv -----
// Front end: accepts input beats, classifies them and buffers them in a
// two-entry command queue. Depends on ghal_pkg.
`default_nettype none

module ghal_front import ghal_pkg::*; #(
  parameter int SLOT_COUNT = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [InDataW-1:0] s_axis_tdata,   // handle_slot, handle_version
  input  wire logic [1:0]         s_axis_tuser,   // operation
  output logic                    cmd_valid_o,
  output cmd_t                    cmd_o,
  input  wire logic               cmd_pop_i
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_new;
  logic       push;
  logic       pop;

  always_comb begin
    cmd_new.slot    = s_axis_tdata[FieldW-1:0];
    cmd_new.version = s_axis_tdata[2*FieldW-1:FieldW];
    cmd_new.usable  = (cmd_new.version != '0) && (32'(cmd_new.slot) < 32'(SLOT_COUNT));
    case (s_axis_tuser)
      OP_CREATE:  cmd_new.kind = KIND_CREATE;
      OP_DESTROY: cmd_new.kind = KIND_DESTROY;
      default:    cmd_new.kind = KIND_QUERY;
    endcase
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (cnt_q != 2'd0);
  assign pop           = cmd_valid_o && cmd_pop_i;
  assign cmd_o         = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ghal_back.sv -----
// Back end: version table, free-handle queue and counters; executes one
// command by reading its memories and then writing them. Depends on ghal_pkg.
`default_nettype none

module ghal_back import ghal_pkg::*; #(
  parameter int SLOT_COUNT  = 256,
  parameter int VERSION_MAX = 255
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cmd_valid_i,
  input  wire cmd_t                cmd_i,
  output logic                     cmd_pop_o,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,  // out_slot, out_version, is_live, live_count
  output logic [1:0]               m_axis_tuser   // status
);

  localparam int SlotW  = $clog2(SLOT_COUNT);
  localparam int FreshW = $clog2(SLOT_COUNT + 1);
  localparam int VerW   = (VERSION_MAX > 255) ? 9 : $clog2(VERSION_MAX + 1);
  localparam int CmpW   = (VerW > FieldW) ? VerW : FieldW;
  localparam int SelW   = (FreshW > FieldW) ? FreshW : FieldW;
  localparam int EntW   = 2 * FieldW;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e             state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [SlotW-1:0]   head_q, head_d;
  logic [SlotW-1:0]   tail_q, tail_d;
  logic [FreshW-1:0]  fill_q, fill_d;
  logic [FreshW-1:0]  fresh_q, fresh_d;
  logic [FreshW-1:0]  live_q, live_d;
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic [FieldW-1:0]  out_slot_q, out_slot_d;
  logic [FieldW-1:0]  out_ver_q, out_ver_d;
  logic               out_live_q, out_live_d;

  logic [VerW-1:0]    vmem [SLOT_COUNT];
  logic [EntW-1:0]    qmem [SLOT_COUNT];
  logic [VerW-1:0]    ver_rd_q;
  logic [EntW-1:0]    ent_rd_q;

  logic               vm_we;
  logic [SlotW-1:0]   vm_wa;
  logic [VerW-1:0]    vm_wd;
  logic               qm_we;
  logic               rd_en;

  logic               exec_go;
  logic [VerW-1:0]    stored_ver;
  logic               alive;
  logic [FieldW-1:0]  base_ver;
  logic [FieldW:0]    bumped_ver;
  logic [SelW-1:0]    cr_slot;
  logic [FieldW:0]    cr_ver;
  logic               cr_got;

  assign rd_en     = (state_q == S_IDLE) && cmd_valid_i;
  assign cmd_pop_o = rd_en;
  assign exec_go   = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);

  always_comb begin
    if ((cmd_q.slot == '0) || (SelW'(cmd_q.slot) >= SelW'(fresh_q))) begin
      stored_ver = '0;
    end else begin
      stored_ver = ver_rd_q;
    end
    alive = cmd_q.usable && (CmpW'(stored_ver) == CmpW'(cmd_q.version));

    base_ver = ent_rd_q[FieldW-1:0];
    if (32'(base_ver) >= 32'(VERSION_MAX)) begin
      bumped_ver = (FieldW + 1)'(1);
    end else begin
      bumped_ver = {1'b0, base_ver} + (FieldW + 1)'(1);
    end

    cr_got  = 1'b0;
    cr_slot = '0;
    cr_ver  = '0;
    if (fill_q != '0) begin
      cr_got  = 1'b1;
      cr_slot = SelW'(ent_rd_q[EntW-1:FieldW]);
      cr_ver  = bumped_ver;
    end else if (32'(fresh_q) < 32'(SLOT_COUNT)) begin
      cr_got  = 1'b1;
      cr_slot = SelW'(fresh_q);
      cr_ver  = (FieldW + 1)'(1);
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    head_d       = head_q;
    tail_d       = tail_q;
    fill_d       = fill_q;
    fresh_d      = fresh_q;
    live_d       = live_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_ver_d    = out_ver_q;
    out_live_d   = out_live_q;
    vm_we        = 1'b0;
    vm_wa        = SlotW'(cmd_q.slot);
    vm_wd        = '0;
    qm_we        = 1'b0;

    if (rd_en) begin
      cmd_d   = cmd_i;
      state_d = S_EXEC;
    end

    if (exec_go) begin
      state_d      = S_IDLE;
      out_valid_d  = 1'b1;
      out_status_d = ST_OK;
      out_slot_d   = cmd_q.slot;
      out_ver_d    = cmd_q.version;
      out_live_d   = 1'b0;
      case (cmd_q.kind)
        KIND_CREATE: begin
          if (fill_q != '0) begin
            head_d = (head_q == SlotW'(SLOT_COUNT - 1)) ? '0 : head_q + SlotW'(1);
            fill_d = fill_q - FreshW'(1);
          end else if (cr_got) begin
            fresh_d = fresh_q + FreshW'(1);
          end
          if (cr_got && (32'(cr_slot) < 32'(SLOT_COUNT))) begin
            vm_we      = 1'b1;
            vm_wa      = SlotW'(cr_slot);
            vm_wd      = VerW'(cr_ver);
            live_d     = live_q + FreshW'(1);
            out_slot_d = cr_slot[FieldW-1:0];
            out_ver_d  = cr_ver[FieldW-1:0];
            out_live_d = 1'b1;
          end else begin
            out_status_d = ST_NO_SLOT;
            out_slot_d   = '0;
            out_ver_d    = '0;
          end
        end
        KIND_DESTROY: begin
          if (alive) begin
            vm_we = 1'b1;
            vm_wd = '0;
            if (32'(fill_q) < 32'(SLOT_COUNT)) begin
              qm_we  = 1'b1;
              tail_d = (tail_q == SlotW'(SLOT_COUNT - 1)) ? '0 : tail_q + SlotW'(1);
              fill_d = fill_q + FreshW'(1);
            end
            if (live_q != '0) begin
              live_d = live_q - FreshW'(1);
            end
          end else begin
            out_status_d = ST_NOT_ALIVE;
          end
        end
        default: begin
          if (alive) begin
            out_live_d = 1'b1;
          end else begin
            out_status_d = ST_NOT_ALIVE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      fill_q       <= '0;
      fresh_q      <= FreshW'(1);
      live_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_slot_q   <= '0;
      out_ver_q    <= '0;
      out_live_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      fill_q       <= fill_d;
      fresh_q      <= fresh_d;
      live_q       <= live_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
      out_ver_q    <= out_ver_d;
      out_live_q   <= out_live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vm_we) begin
      vmem[vm_wa] <= vm_wd;
    end
    if (rd_en) begin
      ver_rd_q <= vmem[SlotW'(cmd_i.slot)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (qm_we) begin
      qmem[tail_q] <= {cmd_q.slot, cmd_q.version};
    end
    if (rd_en) begin
      ent_rd_q <= qmem[head_q];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {(OutDataW - 3 * FieldW - 1)'(0), FieldW'(live_q), out_live_q,
                          out_ver_q, out_slot_q};

endmodule

`default_nettype wire

// ----- rtl/generational_handle_allocator.sv -----
// Top level of the generational handle allocator: command front end,
// queue, and executing back end. Depends on ghal_pkg, ghal_front, ghal_back.
//
//   channel   dir  tdata                                     tuser
//   s_axis    in   [7:0] handle_slot [15:8] handle_version    [1:0] operation
//   m_axis    out  [7:0] out_slot [15:8] out_version          [1:0] status
//                  [16] is_live [24:17] live_count
//
// The back end handles each item by first reading the version table and the
// free-handle queue memory, then writing them and loading the result register.
// The front end buffers up to two commands while the back end works.
// Reset leaves no slot alive; no clearing pass is needed, since slots at or
// above the next fresh id read as version zero.
// A stalled result holds the back end in its write cycle; the front keeps
// accepting until its queue is full.
`default_nettype none

module generational_handle_allocator import ghal_pkg::*; #(
  parameter int SLOT_COUNT  = 256,
  parameter int VERSION_MAX = 255
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // handle_slot, handle_version
  input  wire logic [1:0]          s_axis_tuser,   // operation
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // out_slot, out_version, is_live, live_count
  output logic [1:0]               m_axis_tuser    // status
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  ghal_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  ghal_back #(
    .SLOT_COUNT  (SLOT_COUNT),
    .VERSION_MAX (VERSION_MAX)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ----- rtl/ghal_checker.sv -----
// Port-level checks on the result stream of the handle allocator, bound
// to the top level. Depends on ghal_pkg and generational_handle_allocator.
`default_nettype none

module ghal_port_checks import ghal_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_tvalid_i,
  input wire logic                m_tready_i,
  input wire logic [OutDataW-1:0] m_tdata_i,
  input wire logic [1:0]          m_tuser_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i))
    else $error("result beat changed while stalled");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i == ST_NO_SLOT) |-> (m_tdata_i[16:0] == '0))
    else $error("failed create carries a handle");

  a_dead_not_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i == ST_NOT_ALIVE) |-> !m_tdata_i[16])
    else $error("dead handle reported live");

  a_live_version: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tdata_i[16] |-> (m_tuser_i == ST_OK) && (m_tdata_i[15:8] != '0))
    else $error("live handle with zero version or bad status");

endmodule

bind generational_handle_allocator ghal_port_checks u_ghal_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata),
  .m_tuser_i  (m_axis_tuser)
);

`default_nettype wire

// ----- test/ghal_checker.sv -----
// Result checker for the generational handle allocator: follows the command and
// result streams, predicts every result beat and compares it field by field.
// Depends on ghal_pkg.
`timescale 1ns / 1ps

module ghal_checker import ghal_pkg::*; #(
  parameter int SLOT_COUNT  = 256,
  parameter int VERSION_MAX = 255
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // handle_slot, handle_version
  input  logic [1:0]          s_axis_tuser,   // operation
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,   // out_slot, out_version, is_live, live_count
  input  logic [1:0]          m_axis_tuser,   // status
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  refused_o,
  output int                  wraps_o
);

  localparam int PadLsb = 3 * FieldW + 1;

  typedef struct packed {
    status_e           status;
    logic [FieldW-1:0] slot;
    logic [FieldW-1:0] version;
    logic              live;
    logic [FieldW-1:0] count;
  } outcome_t;

  logic [FieldW-1:0]   slot_ver [SLOT_COUNT];
  logic [2*FieldW-1:0] freed_handles[$];
  outcome_t            awaited_results[$];
  int                  next_fresh;
  int                  live_total;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic bit handle_alive(input logic [FieldW-1:0] slot,
                                      input logic [FieldW-1:0] ver);
    if (ver == '0 || slot >= SLOT_COUNT) return 1'b0;
    return slot_ver[slot] == ver;
  endfunction

  task automatic apply_command(input logic [1:0] op, input logic [FieldW-1:0] slot,
                               input logic [FieldW-1:0] ver, output outcome_t r);
    logic [2*FieldW-1:0] entry;
    r.status  = ST_OK;
    r.slot    = slot;
    r.version = ver;
    r.live    = 1'b0;
    if (op == OP_CREATE) begin
      if (freed_handles.size() != 0) begin
        entry  = freed_handles.pop_front();
        r.slot = entry[2*FieldW-1:FieldW];
        if (entry[FieldW-1:0] >= VERSION_MAX) begin
          r.version = FieldW'(1);
          wraps_o++;
        end else begin
          r.version = entry[FieldW-1:0] + 1'b1;
        end
      end else if (next_fresh < SLOT_COUNT) begin
        r.slot    = next_fresh[FieldW-1:0];
        r.version = FieldW'(1);
        next_fresh++;
      end else begin
        r.status = ST_NO_SLOT;
      end
      if (r.status == ST_OK) begin
        slot_ver[r.slot] = r.version;
        live_total++;
        r.live = 1'b1;
      end else begin
        r.slot    = '0;
        r.version = '0;
        refused_o++;
      end
    end else if (op == OP_DESTROY) begin
      if (handle_alive(slot, ver)) begin
        slot_ver[slot] = '0;
        if (freed_handles.size() < SLOT_COUNT) freed_handles.push_back({slot, ver});
        if (live_total != 0) live_total--;
      end else begin
        r.status = ST_NOT_ALIVE;
      end
    end else begin
      if (handle_alive(slot, ver)) r.live = 1'b1;
      else r.status = ST_NOT_ALIVE;
    end
    r.count = live_total[FieldW-1:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    outcome_t want;
    if (!rst_ni) begin
      foreach (slot_ver[i]) slot_ver[i] = '0;
      freed_handles.delete();
      awaited_results.delete();
      next_fresh   = 1;
      live_total   = 0;
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      refused_o    = 0;
      wraps_o      = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        checked_o++;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing outstanding: tdata %h tuser %0d",
                                    m_axis_tdata, m_axis_tuser));
        end else begin
          want = awaited_results.pop_front();
          if (m_axis_tuser !== want.status)
            report_mismatch($sformatf("status: expected %0d, got %0d",
                                      want.status, m_axis_tuser));
          if (m_axis_tdata[FieldW-1:0] !== want.slot)
            report_mismatch($sformatf("out_slot: expected %0d, got %0d",
                                      want.slot, m_axis_tdata[FieldW-1:0]));
          if (m_axis_tdata[2*FieldW-1:FieldW] !== want.version)
            report_mismatch($sformatf("out_version: expected %0d, got %0d",
                                      want.version, m_axis_tdata[2*FieldW-1:FieldW]));
          if (m_axis_tdata[2*FieldW] !== want.live)
            report_mismatch($sformatf("is_live: expected %0d, got %0d",
                                      want.live, m_axis_tdata[2*FieldW]));
          if (m_axis_tdata[PadLsb-1:2*FieldW+1] !== want.count)
            report_mismatch($sformatf("live_count: expected %0d, got %0d",
                                      want.count, m_axis_tdata[PadLsb-1:2*FieldW+1]));
          if (m_axis_tdata[OutDataW-1:PadLsb] !== '0)
            report_mismatch($sformatf("tdata padding not zero: %h", m_axis_tdata));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_command(s_axis_tuser, s_axis_tdata[FieldW-1:0],
                      s_axis_tdata[2*FieldW-1:FieldW], want);
        awaited_results.push_back(want);
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

// ----- test/tb_generational_handle_allocator.sv -----
// Top of the generational handle allocator testbench: clock, reset, command
// stimulus and result back-pressure. Depends on ghal_pkg, ghal_checker and the block.
`timescale 1ns / 1ps

module tb_generational_handle_allocator;
  import ghal_pkg::*;

  localparam int SLOT_COUNT  = 256;
  localparam int VERSION_MAX = 255;
  localparam logic [1:0] OP_ALT_QUERY = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int CHURN_PAIRS = 270;
  localparam int MIX_ITEMS   = 550;

  typedef struct packed {
    logic [FieldW-1:0] slot;
    logic [FieldW-1:0] version;
  } handle_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = OP_CREATE;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  int fail_count, pending, checked, refused, wraps;
  int sent = 0;
  int cycles = 0;
  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;
  handle_t    live_pool[$];
  logic [1:0] op_trail[$];

  generational_handle_allocator #(
    .SLOT_COUNT (SLOT_COUNT),
    .VERSION_MAX(VERSION_MAX)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  ghal_checker #(
    .SLOT_COUNT (SLOT_COUNT),
    .VERSION_MAX(VERSION_MAX)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .refused_o    (refused),
    .wraps_o      (wraps)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Collect created handles so later commands can target live ones.
  always @(posedge clk_i) begin : follow_results
    logic [1:0] op;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready && op_trail.size() != 0) begin
        op = op_trail.pop_front();
        if (op == OP_CREATE && m_axis_tuser == ST_OK)
          live_pool.push_back({m_axis_tdata[FieldW-1:0], m_axis_tdata[2*FieldW-1:FieldW]});
      end
      if (s_axis_tvalid && s_axis_tready) op_trail.push_back(s_axis_tuser);
    end
  end

  initial begin : accept_results
    int stall;
    forever begin
      if ($urandom_range(0, 63) == 0) sink_steady = !sink_steady;
      stall = sink_steady ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && rst_ni));
    end
  end

  task automatic send_command(input logic [1:0] op, input logic [FieldW-1:0] slot,
                              input logic [FieldW-1:0] ver);
    int gap;
    if ($urandom_range(0, 63) == 0) src_steady = !src_steady;
    gap = src_steady ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ver, slot};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  // Hold off new commands until every result beat is back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic pick_handle(input bit take, output handle_t h);
    int idx;
    if (live_pool.size() == 0 || $urandom_range(0, 7) == 0) begin
      h.slot    = FieldW'($urandom_range(0, 255));
      h.version = FieldW'($urandom_range(0, 255));
    end else begin
      idx = $urandom_range(0, live_pool.size() - 1);
      h   = live_pool[idx];
      if (take) live_pool.delete(idx);
      else if ($urandom_range(0, 5) == 0) h.version = h.version + 1'b1;
    end
  endtask

  task automatic random_command(input int create_pct, input int destroy_pct);
    handle_t h;
    int      r;
    r = $urandom_range(0, 99);
    if (r < create_pct) begin
      send_command(OP_CREATE, FieldW'($urandom_range(0, 255)), FieldW'($urandom_range(0, 255)));
    end else if (r < create_pct + destroy_pct) begin
      pick_handle(1'b1, h);
      send_command(OP_DESTROY, h.slot, h.version);
    end else begin
      pick_handle(1'b0, h);
      send_command((r >= 95) ? OP_ALT_QUERY : OP_QUERY, h.slot, h.version);
    end
  endtask

  initial begin : stimulus
    handle_t h;
    int      base;
    int      n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_command(OP_QUERY, 8'd0, 8'd0);
    send_command(OP_QUERY, 8'd255, 8'd255);
    send_command(OP_DESTROY, 8'd1, 8'd1);
    send_command(OP_CREATE, 8'd0, 8'd0);
    send_command(OP_CREATE, 8'd0, 8'd0);
    send_command(OP_QUERY, 8'd1, 8'd1);
    send_command(OP_ALT_QUERY, 8'd2, 8'd1);
    send_command(OP_QUERY, 8'd1, 8'd0);
    send_command(OP_QUERY, 8'd2, 8'd2);
    send_command(OP_DESTROY, 8'd2, 8'd1);
    send_command(OP_DESTROY, 8'd2, 8'd1);
    send_command(OP_QUERY, 8'd2, 8'd1);
    send_command(OP_DESTROY, 8'd1, 8'd0);
    send_command(OP_CREATE, 8'd0, 8'd0);
    send_command(OP_DESTROY, 8'd1, 8'd1);
    send_command(OP_DESTROY, 8'd2, 8'd2);
    send_command(OP_CREATE, 8'd0, 8'd0);
    send_command(OP_QUERY, 8'd0, 8'd1);
    send_command(OP_DESTROY, 8'd1, 8'd2);
    send_command(OP_CREATE, 8'd255, 8'd255);
    send_command(OP_QUERY, 8'd255, 8'd0);
    settle();
    live_pool.delete();

    // One freed handle left: cycle it until its version wraps.
    repeat (CHURN_PAIRS) begin
      base = live_pool.size();
      send_command(OP_CREATE, FieldW'($urandom_range(0, 255)), FieldW'($urandom_range(0, 255)));
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while (live_pool.size() <= base);
      h = live_pool.pop_back();
      if ($urandom_range(0, 3) == 0) send_command(OP_QUERY, h.slot, h.version);
      send_command(OP_DESTROY, h.slot, h.version);
      if ($urandom_range(0, 3) == 0) send_command(OP_QUERY, h.slot, h.version);
    end
    settle();

    repeat (MIX_ITEMS) random_command(40, 30);
    settle();

    base = refused;
    n = 0;
    while (refused - base < 6 && n < 600) begin
      random_command(85, 0);
      n++;
    end
    settle();

    n = 0;
    while (live_pool.size() != 0 && n < 800) begin
      random_command(8, 70);
      n++;
    end
    settle();
    repeat (20) @(posedge clk_i);

    $display("Issued %0d commands, checked %0d result beats: %0d creates refused when full,",
             sent, checked, refused);
    $display("%0d version wraps on a reused slot", wraps);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- generational_handle_allocator.f -----
rtl/ghal_pkg.sv
rtl/ghal_front.sv
rtl/ghal_back.sv
rtl/generational_handle_allocator.sv
rtl/ghal_checker.sv
test/ghal_checker.sv
test/tb_generational_handle_allocator.sv
